### rtl/core/sliding_window_minimum_core_macros.svh
// Assertion macros shared by the checker of the sliding window minimum core.
// Both expect signals named clock and reset in the scope of use.
`ifndef SLIDING_WINDOW_MINIMUM_CORE_MACROS_SVH
`define SLIDING_WINDOW_MINIMUM_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SWMIN_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sliding window minimum check failed");

// Consequent checked in the cycle after the antecedent completes.
`define SWMIN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sliding window minimum check failed");

`endif

### rtl/core/swmin_pkg.sv
package swmin_pkg;

   localparam int SAMPLE_WIDTH        = 32;
   localparam int WINDOW_LENGTH_WIDTH = 7;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic       accept;
      logic       clear;
      sample_type sample;
   } cell_ctrl_type;

   // Candidate as one cell hands it to its neighbour.
   typedef struct packed {
      logic       valid;
      sample_type value;
   } cell_link_type;

endpackage

### rtl/core/swmin_cell.sv
module swmin_cell
   import swmin_pkg::*;
#(
   parameter int AGE_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic                shift,
   input  logic                prev_keep,
   output logic                keep,
   input  cell_link_type       next_post,
   input  logic [AGE_BITS-1:0] next_post_age,
   output cell_link_type       post,
   output logic [AGE_BITS-1:0] post_age
);

   logic                valid_ff, valid_in;
   sample_type          value_ff, value_in;
   logic [AGE_BITS-1:0] age_ff, age_in;
   logic                insert;

   // A candidate survives when it is not strictly greater than the new sample.
   assign keep   = valid_ff && (value_ff <= ctrl.sample);
   // The new sample lands in the first cell behind the surviving candidates.
   assign insert = !keep && prev_keep;

   assign post.valid = keep || insert;
   assign post.value = keep ? value_ff : ctrl.sample;
   assign post_age   = keep ? age_ff + AGE_BITS'(1) : '0;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.accept && shift) begin
         valid_in = next_post.valid;
         value_in = next_post.value;
         age_in   = next_post_age;
      end else if (ctrl.accept) begin
         valid_in = post.valid;
         value_in = post.value;
         age_in   = post_age;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      age_ff   <= age_in;
   end

endmodule

### rtl/core/sliding_window_minimum_core.sv
// Sliding window minimum core: one signed sample in, the window minimum out.
// A result is in the output register in the cycle after its sample's transfer. One sample
// per cycle is taken unless a result is stalled: each cell has one compare-and-move step.
// The first window length minus one samples after reset or a window write give no result.
// Reset (synchronous, active high) empties the cell chain, zeroes the fill count,
// sets the window length to one and drops any pending result.
module sliding_window_minimum_core
   import swmin_pkg::*;
#(
   parameter int WINDOW_MAX = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_window_min,
   input  logic                           csr_write_enable,
   input  logic [WINDOW_LENGTH_WIDTH-1:0] csr_window_length
);

   // Ages and the fill count never exceed the window length minus one.
   localparam int AGE_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   // The deque of candidate minima lives in a row of cells, front in cell zero,
   // ordered from oldest to newest and non-decreasing in value. Each cell also
   // carries the age of its candidate in samples, which replaces the sample
   // history: the front leaves the window exactly when its age reaches the
   // window length minus one at a sample that gives a result.

   logic [AGE_BITS-1:0] lim_ff, lim_in;     // effective window length minus one
   logic [AGE_BITS-1:0] fill_ff, fill_in;   // samples held in the current window
   logic                rsp_valid_ff, rsp_valid_in;
   sample_type          rsp_window_min_ff, rsp_window_min_in;

   cell_ctrl_type       ctrl;
   logic                accept;
   logic                emit;
   logic                shift;

   logic                keep_chain [WINDOW_MAX+1];
   cell_link_type       link_chain [WINDOW_MAX+1];
   logic [AGE_BITS-1:0] age_chain  [WINDOW_MAX+1];

   // A result that waits on a stalled consumer holds the input side.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // The window is full once this sample arrives, so a result follows.
   assign emit = (fill_ff == lim_ff);

   assign ctrl.accept = accept;
   assign ctrl.clear  = csr_write_enable;
   assign ctrl.sample = req_sample;

   // Cell zero always sees a surviving neighbour ahead of it, and the cell past
   // the end of the row hands over nothing.
   assign keep_chain[0]          = 1'b1;
   assign link_chain[WINDOW_MAX] = '0;
   assign age_chain[WINDOW_MAX]  = '0;

   // After the new sample has been placed, the front of the deque is the window
   // minimum. It is retired when it is the oldest sample of a full window.
   assign shift = emit && (age_chain[0] == lim_ff);

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swmin_cell #(
         .AGE_BITS(AGE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .shift        (shift),
         .prev_keep    (keep_chain[i]),
         .keep         (keep_chain[i+1]),
         .next_post    (link_chain[i+1]),
         .next_post_age(age_chain[i+1]),
         .post         (link_chain[i]),
         .post_age     (age_chain[i])
      );
   end

   // A window length of zero counts as one, and one above the capacity is
   // saturated to it. Writing the length empties the window.
   always_comb begin
      lim_in = lim_ff;
      if (csr_write_enable) begin
         priority if (csr_window_length == '0) begin
            lim_in = '0;
         end else if (int'(csr_window_length) > WINDOW_MAX) begin
            lim_in = AGE_BITS'(WINDOW_MAX - 1);
         end else begin
            lim_in = AGE_BITS'(csr_window_length - WINDOW_LENGTH_WIDTH'(1));
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      priority if (csr_write_enable) begin
         fill_in = '0;
      end else if (accept && !emit) begin
         fill_in = fill_ff + AGE_BITS'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   // The output register is reloaded on the transfer of a sample that completes
   // a window, and drains when the consumer takes its transfer.
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_window_min_in = rsp_window_min_ff;
      priority if (accept && emit) begin
         rsp_valid_in      = 1'b1;
         rsp_window_min_in = link_chain[0].value;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lim_ff       <= lim_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_window_min_ff <= rsp_window_min_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_min = rsp_window_min_ff;

endmodule

### rtl/core/swmin_check.sv
`include "sliding_window_minimum_core_macros.svh"

module swmin_check
   import swmin_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_window_min,
   input logic                           csr_write_enable,
   input logic [WINDOW_LENGTH_WIDTH-1:0] csr_window_length
);

   logic       req_transfer;
   logic       rsp_waiting;
   logic       window_one_write;
   logic       lone_sample;
   logic       sample_echoed;
   sample_type last_req_sample_ff;

   assign req_transfer     = req_valid && !req_stall;
   assign rsp_waiting      = rsp_valid && rsp_stall;
   assign window_one_write = csr_write_enable
                             && (csr_window_length == WINDOW_LENGTH_WIDTH'(1));
   assign lone_sample      = req_transfer && !csr_write_enable;
   assign sample_echoed    = rsp_valid && (rsp_window_min == last_req_sample_ff);

   always_ff @(posedge clock) begin
      last_req_sample_ff <= req_sample;
   end

   // A stalled result keeps its value.
   `SWMIN_ASSERT_NEXT(a_rsp_hold, rsp_waiting, rsp_valid && $stable(rsp_window_min))

   // No sample transfer while a result waits on a stalled consumer.
   `SWMIN_ASSERT_SAME(a_backpressure, rsp_waiting, req_stall)

   // A result only appears after a sample transfer.
   `SWMIN_ASSERT_NEXT(a_no_spurious, !req_transfer && !rsp_waiting, !rsp_valid)

   // A sample transferred right after a write of window length one comes straight back as the minimum.
   `SWMIN_ASSERT_NEXT(a_window_one, window_one_write ##1 lone_sample, sample_echoed)

endmodule

bind sliding_window_minimum_core swmin_check u_swmin_check (.*);
